### sv/pca_pkg.sv
`default_nettype none

package pca_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned GainW  = 16;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned ProdW  = ChanW + GainW;      // brightness product
  localparam int unsigned TW     = 25;                 // signed contrast sum, Q.8
  localparam int unsigned YW     = 24;                 // luma, Q.16
  localparam int unsigned DiffW  = YW + 1;             // signed (c << 16) - y
  localparam int unsigned SProdW = GainW + DiffW;      // signed saturation product
  localparam int unsigned UW     = SProdW + 1;         // signed mix sum, Q.28

  // Luma weights in Q0.16; they sum to exactly 1.0.
  localparam logic [GainW-1:0] LumaWr = 16'd19595;
  localparam logic [GainW-1:0] LumaWg = 16'd38470;
  localparam logic [GainW-1:0] LumaWb = 16'd7471;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Register reset values: unity for every stage.
  localparam logic [GainW-1:0] BrightnessUnity = 16'd4096;
  localparam logic [GainW-1:0] ContrastUnity   = 16'd256;
  localparam logic [GainW-1:0] SaturationUnity = 16'd4096;

  typedef enum logic [1:0] {
    RegBrightness = 2'd0,
    RegContrast   = 2'd1,
    RegSaturation = 2'd2
  } cfg_idx_e;

  // Sideband that travels with every pixel through the pipeline.
  typedef struct packed {
    logic             vld;
    logic [ChanW-1:0] alpha;
    logic             last;
  } side_t;

  typedef logic [NumCh-1:0][ChanW-1:0] rgb_t;

endpackage

`default_nettype wire

### sv/pixel_color_adjust_unit.sv
`default_nettype none

// Pixel color adjust unit. Each RGBA pixel taken on start passes through a
// brightness gain (unsigned Q4.12), a contrast stretch about 128 (unsigned
// Q8.8 slope, precomputed by the host) and a saturation mix toward luma
// (signed Q4.12), each clamped to 0..255 before the next. Alpha and the
// frame-end mark ride along untouched. The unit takes one pixel every clock:
// busy is never raised. Every pixel leaves through five register stages,
// with valid_o high for a single cycle per pixel; the register stages
// are the brightness multiply, the contrast multiply, the contrast clamp
// with the luma sum, the saturation multiply, and the final sum and clamp
// into the output registers. The receiver cannot hold a beat off, so it
// must take each one in the cycle it appears. Registers are written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i (0: brightness, 1: contrast,
// 2: saturation; other indexes are ignored) and must only change while no
// pixel is in flight. All registers reset to unity, so a fresh unit passes
// color unchanged.
module pixel_color_adjust_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [7:0]                red_in_i,
  input  logic [7:0]                green_in_i,
  input  logic [7:0]                blue_in_i,
  input  logic [7:0]                alpha_in_i,
  input  logic                      frame_end_in_i,
  output logic                      valid_o,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic [7:0]                alpha_out_o,
  output logic                      frame_end_out_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [15:0]               cfg_wdata_i
);
  import pca_pkg::*;

  logic [GainW-1:0] bright_q, contrast_q, sat_q;
  side_t            side_in, side_front, side_luma, side_out;
  rgb_t             rgb_in, rgb_luma, rgb_out;
  logic signed [NumCh-1:0][TW-1:0] t_front;
  logic [YW-1:0]    y_luma;
  cfg_idx_e         cfg_idx;

  // Every cycle can take a pixel.
  assign busy = 1'b0;

  assign side_in.vld   = start && !busy;
  assign side_in.alpha = alpha_in_i;
  assign side_in.last  = frame_end_in_i;
  assign rgb_in        = {blue_in_i, green_in_i, red_in_i};

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= BrightnessUnity;
      contrast_q <= ContrastUnity;
      sat_q      <= SaturationUnity;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        RegBrightness: bright_q   <= cfg_wdata_i;
        RegContrast:   contrast_q <= cfg_wdata_i;
        RegSaturation: sat_q      <= cfg_wdata_i;
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  pca_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_i        (side_in),
    .rgb_i         (rgb_in),
    .bright_gain_i (bright_q),
    .contrast_i    (contrast_q),
    .side_o        (side_front),
    .t_o           (t_front)
  );

  pca_luma u_luma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_front),
    .t_i    (t_front),
    .side_o (side_luma),
    .rgb_o  (rgb_luma),
    .y_o    (y_luma)
  );

  pca_sat u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .side_i     (side_luma),
    .rgb_i      (rgb_luma),
    .y_i        (y_luma),
    .sat_gain_i (sat_q),
    .side_o     (side_out),
    .rgb_o      (rgb_out)
  );

  assign valid_o         = side_out.vld;
  assign red_out_o       = rgb_out[0];
  assign green_out_o     = rgb_out[1];
  assign blue_out_o      = rgb_out[2];
  assign alpha_out_o     = side_out.alpha;
  assign frame_end_out_o = side_out.last;

endmodule

`default_nettype wire

### sv/pca_front.sv
`default_nettype none

// Brightness gain followed by the contrast multiply, two register stages.
module pca_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pca_pkg::side_t                      side_i,
  input  pca_pkg::rgb_t                       rgb_i,
  input  logic [pca_pkg::GainW-1:0]           bright_gain_i,
  input  logic [pca_pkg::GainW-1:0]           contrast_i,
  output pca_pkg::side_t                      side_o,
  output logic signed [pca_pkg::NumCh-1:0][pca_pkg::TW-1:0] t_o
);
  import pca_pkg::*;

  side_t                            side1_q, side2_q;
  logic [NumCh-1:0][ProdW-1:0]      p_d, p_q;
  logic signed [NumCh-1:0][TW-1:0]  t_d, t_q;
  logic [NumCh-1:0][ChanW-1:0]      vb;
  logic signed [NumCh-1:0][TW-1:0]  dlt;
  logic signed [TW-1:0]             cf_s;

  always_comb begin
    cf_s = $signed({{(TW-GainW){1'b0}}, contrast_i});
    for (int i = 0; i < NumCh; i++) begin
      p_d[i] = ProdW'(rgb_i[i]) * ProdW'(bright_gain_i);
      // Brightness result is p >> 12, clamped to 255.
      vb[i]  = (|p_q[i][ProdW-1:20]) ? ChanMax : p_q[i][19:12];
      dlt[i] = $signed({{(TW-ChanW){1'b0}}, vb[i]}) - TW'(signed'(128));
      t_d[i] = TW'(cf_s * dlt[i]) + TW'(signed'(32768));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else begin
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    t_q <= t_d;
  end

  assign side_o = side2_q;
  assign t_o    = t_q;

  // The contrast sum can never leave the span of 65535 * [-128, 127] + 32768.
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side2_q.vld |-> ($signed(t_q[0]) <= TW'(signed'(8355713)) &&
                     $signed(t_q[0]) >= TW'(signed'(-8355712))))
    else $error("contrast sum out of range");

endmodule

`default_nettype wire

### sv/pca_luma.sv
`default_nettype none

// Contrast clamp and luma sum, one register stage.
module pca_luma (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  pca_pkg::side_t                                     side_i,
  input  logic signed [pca_pkg::NumCh-1:0][pca_pkg::TW-1:0]  t_i,
  output pca_pkg::side_t                                     side_o,
  output pca_pkg::rgb_t                                      rgb_o,
  output logic [pca_pkg::YW-1:0]                             y_o
);
  import pca_pkg::*;

  side_t          side_q;
  rgb_t           c_d, c_q;
  logic [YW-1:0]  y_d, y_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      if (t_i[i][TW-1]) begin
        c_d[i] = '0;
      end else if (|t_i[i][TW-2:16]) begin
        c_d[i] = ChanMax;
      end else begin
        c_d[i] = t_i[i][15:8];
      end
    end
    y_d = YW'(c_d[0]) * YW'(LumaWr) + YW'(c_d[1]) * YW'(LumaWg) +
          YW'(c_d[2]) * YW'(LumaWb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    y_q <= y_d;
  end

  assign side_o = side_q;
  assign rgb_o  = c_q;
  assign y_o    = y_q;

  // The weights sum to one, so luma never exceeds full scale.
  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q.vld |-> (y_q <= 24'hFF0000))
    else $error("luma above full scale");

endmodule

`default_nettype wire

### sv/pca_sat.sv
`default_nettype none

// Saturation mix toward luma: a multiply stage, then the sum and clamp.
module pca_sat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pca_pkg::side_t                side_i,
  input  pca_pkg::rgb_t                 rgb_i,
  input  logic [pca_pkg::YW-1:0]        y_i,
  input  logic [pca_pkg::GainW-1:0]     sat_gain_i,
  output pca_pkg::side_t                side_o,
  output pca_pkg::rgb_t                 rgb_o
);
  import pca_pkg::*;

  side_t                               side1_q, side2_q;
  logic signed [NumCh-1:0][DiffW-1:0]  diff;
  logic signed [NumCh-1:0][SProdW-1:0] prod_d, prod_q;
  logic [YW-1:0]                       y_q;
  logic signed [NumCh-1:0][UW-1:0]     u;
  rgb_t                                c_d, c_q;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      diff[i]   = $signed({1'b0, rgb_i[i], 16'b0}) - $signed({1'b0, y_i});
      prod_d[i] = $signed({{(SProdW-GainW){sat_gain_i[GainW-1]}}, sat_gain_i}) *
                  $signed({{(SProdW-DiffW){diff[i][DiffW-1]}}, diff[i]});
      u[i]      = $signed({{(UW-YW-12){1'b0}}, y_q, 12'b0}) +
                  $signed({prod_q[i][SProdW-1], prod_q[i]});
      if (u[i][UW-1]) begin
        c_d[i] = '0;
      end else if (|u[i][UW-2:36]) begin
        c_d[i] = ChanMax;
      end else begin
        c_d[i] = u[i][35:28];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else begin
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    y_q    <= y_i;
    c_q    <= c_d;
  end

  assign side_o = side2_q;
  assign rgb_o  = c_q;

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side2_q.vld == $past(side_i.vld, 2))
    else $error("saturation stage lost or invented a beat");

  // With a zero gain every channel collapses onto the same luma value.
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side2_q.vld && sat_gain_i == '0 && $past(sat_gain_i) == '0) |->
      (c_q[0] == c_q[1] && c_q[1] == c_q[2]))
    else $error("grayscale mix gave unequal channels");

endmodule

`default_nettype wire
